FILE: rtl/kme_pkg.sv
// Shared types and constants for the keypad to MIDI note event encoder.
package kme_pkg;

   // Input scan layout.
   localparam int KEY_BITS       = 6;
   localparam int FIRST_NOTE_KEY = 2;
   localparam int MAX_KEYS       = KEY_BITS - FIRST_NOTE_KEY;

   // Field widths.
   localparam int NOTE_W     = 7;
   localparam int VEL_W      = 7;
   localparam int CHAN_W     = 5;
   localparam int LED_W      = 4;
   localparam int LAYER_W    = 2;
   localparam int KEY_IDX_W  = 2;
   localparam int MAX_TABLES = 4;
   localparam int TABLE_W    = MAX_KEYS * NOTE_W;

   // Stream and register port widths.
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 28;

   // Scan command queue.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER0_NOTES = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER1_NOTES = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER2_NOTES = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER3_NOTES = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ON_VELOCITY  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIDI_CHANNEL = 3'd5;

   // Register reset values.
   localparam logic [VEL_W-1:0]  VEL_RESET  = 7'd99;
   localparam logic [CHAN_W-1:0] CHAN_RESET = 5'd1;

   typedef logic [MAX_KEYS-1:0] key_mask_type;

   // One classified scan, handed from the front end to the sequencer.
   typedef struct packed {
      logic [LAYER_W-1:0] layer;
      key_mask_type       on_mask;
      key_mask_type       off_mask;
      key_mask_type       held;
   } scan_cmd_type;

   // Configuration register file contents.
   typedef struct packed {
      logic [MAX_TABLES-1:0][TABLE_W-1:0] note_tables;
      logic [VEL_W-1:0]                   on_velocity;
      logic [CHAN_W-1:0]                  midi_channel;
   } cfg_type;

   // Queue status seen by both ends.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // One result word.
   typedef struct packed {
      logic              event_valid;
      logic              is_note_on;
      logic [NOTE_W-1:0] note_number;
      logic [VEL_W-1:0]  note_velocity;
      logic [CHAN_W-1:0] channel_out;
      logic [LED_W-1:0]  led_mask;
      logic              last_of_scan;
   } result_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

endpackage

FILE: rtl/kme_front.sv
// Front end: accepts key scans, tracks held keys and classifies the events of each scan.
module kme_front #(
   parameter int NOTE_KEYS = 4,
   parameter int LAYERS    = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [kme_pkg::KEY_BITS-1:0]   key_bits,
   input  kme_pkg::queue_status_type      queue_status,
   output logic                           queue_push,
   output kme_pkg::scan_cmd_type          queue_cmd
);

   // Note keys beyond the input bits are never pressed.
   localparam int ACTIVE_KEYS = (NOTE_KEYS < kme_pkg::MAX_KEYS) ? NOTE_KEYS : kme_pkg::MAX_KEYS;
   localparam int LAST_LAYER  = LAYERS - 1;
   localparam kme_pkg::key_mask_type ACTIVE_MASK =
      kme_pkg::key_mask_type'((1 << ACTIVE_KEYS) - 1);

   kme_pkg::key_mask_type        held_ff;
   kme_pkg::key_mask_type        held_in;
   kme_pkg::key_mask_type        pressed;
   logic [kme_pkg::LAYER_W-1:0]  mod_sum;
   logic [kme_pkg::LAYER_W-1:0]  layer;
   logic                         accept;

   always_comb begin
      // Modifier keys weigh 1 and 2; their sum saturates at the top layer.
      mod_sum = {key_bits[1], key_bits[0]};
      if (int'(mod_sum) > LAST_LAYER) begin
         layer = kme_pkg::LAYER_W'(LAST_LAYER);
      end else begin
         layer = mod_sum;
      end
      pressed = key_bits[kme_pkg::KEY_BITS-1:kme_pkg::FIRST_NOTE_KEY] & ACTIVE_MASK;
   end

   assign req_tready = !queue_status.full;
   assign accept     = req_tvalid && req_tready;
   assign queue_push = accept;

   always_comb begin
      queue_cmd.layer    = layer;
      queue_cmd.on_mask  = pressed & ~held_ff;
      queue_cmd.off_mask = ~pressed & held_ff;
      queue_cmd.held     = pressed;
      held_in            = accept ? pressed : held_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   a_masks_disjoint: assert property (@(posedge clock) disable iff (reset)
      queue_push |-> (queue_cmd.on_mask & queue_cmd.off_mask) == '0)
      else $error("key both pressed and released in one scan");

   a_layer_range: assert property (@(posedge clock) disable iff (reset)
      queue_push |-> int'(queue_cmd.layer) <= LAST_LAYER)
      else $error("layer beyond the configured layer count");

   a_held_inactive: assert property (@(posedge clock) disable iff (reset)
      (held_ff & ~ACTIVE_MASK) == '0)
      else $error("held bit set for a key that does not exist");

endmodule

FILE: rtl/kme_queue.sv
// Short queue of classified scans between the front end and the sequencer.
module kme_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  kme_pkg::scan_cmd_type      push_cmd,
   input  logic                       pop,
   output kme_pkg::scan_cmd_type      pop_cmd,
   output kme_pkg::queue_status_type  status
);

   kme_pkg::scan_cmd_type         entry_ff [kme_pkg::QUEUE_DEPTH];
   logic [kme_pkg::QPTR_W-1:0]    wr_ptr_ff;
   logic [kme_pkg::QPTR_W-1:0]    wr_ptr_in;
   logic [kme_pkg::QPTR_W-1:0]    rd_ptr_ff;
   logic [kme_pkg::QPTR_W-1:0]    rd_ptr_in;
   logic [kme_pkg::QPTR_W:0]      count_ff;
   logic [kme_pkg::QPTR_W:0]      count_in;

   localparam logic [kme_pkg::QPTR_W-1:0] LAST_PTR = kme_pkg::QPTR_W'(kme_pkg::QUEUE_DEPTH - 1);

   always_comb begin
      status.full  = (count_ff == (kme_pkg::QPTR_W + 1)'(kme_pkg::QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      pop_cmd      = entry_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("scan queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("scan queue read while empty");

   a_ptr_spacing: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || status.full) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with the fill count");

endmodule

FILE: rtl/kme_back.sv
// Sequencer: expands one classified scan into note events, one result word per cycle while the output register is free.
module kme_back #(
   parameter int LAYERS = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  kme_pkg::cfg_type           cfg,
   input  kme_pkg::queue_status_type  queue_status,
   input  kme_pkg::scan_cmd_type      queue_cmd,
   output logic                       queue_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output kme_pkg::result_type        rsp_word
);

   localparam logic [kme_pkg::LAYER_W-1:0] LAST_LAYER = kme_pkg::LAYER_W'(LAYERS - 1);

   kme_pkg::back_state_type            state_ff;
   kme_pkg::back_state_type            state_in;
   kme_pkg::scan_cmd_type              cmd_ff;
   kme_pkg::key_mask_type              pend_ff;
   kme_pkg::key_mask_type              pend_in;
   logic [kme_pkg::LAYER_W-1:0]        lay_ff;
   logic [kme_pkg::LAYER_W-1:0]        lay_in;
   logic                               rsp_valid_ff;
   kme_pkg::result_type                rsp_word_ff;
   kme_pkg::result_type                word_in;

   logic                               out_free;
   logic                               emit;
   logic                               has_event;
   logic [kme_pkg::KEY_IDX_W-1:0]      cur_key;
   logic                               cur_on;
   logic                               key_done;
   logic                               last_word;
   logic [kme_pkg::LAYER_W-1:0]        note_layer;
   logic [kme_pkg::MAX_KEYS-1:0][kme_pkg::NOTE_W-1:0] layer_notes;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kme_pkg::BACK_IDLE: begin
            if (!queue_status.empty) begin
               state_in = kme_pkg::BACK_RUN;
            end
         end
         kme_pkg::BACK_RUN: begin
            if (emit && last_word) begin
               state_in = kme_pkg::BACK_IDLE;
            end
         end
         default: state_in = kme_pkg::BACK_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      queue_pop = 1'b0;
      emit      = 1'b0;
      unique case (state_ff)
         kme_pkg::BACK_IDLE: queue_pop = !queue_status.empty;
         kme_pkg::BACK_RUN:  emit      = out_free;
         default: begin
            queue_pop = 1'b0;
            emit      = 1'b0;
         end
      endcase
   end

   // Pick the lowest key with pending work and build its word.
   always_comb begin
      has_event = |pend_ff;
      cur_key   = '0;
      for (int k = kme_pkg::MAX_KEYS - 1; k >= 0; k--) begin
         if (pend_ff[k]) begin
            cur_key = kme_pkg::KEY_IDX_W'(k);
         end
      end
      cur_on     = cmd_ff.on_mask[cur_key];
      note_layer = cur_on ? cmd_ff.layer : lay_ff;
      layer_notes = cfg.note_tables[note_layer];
      key_done   = cur_on || (lay_ff == LAST_LAYER);

      pend_in = pend_ff;
      if (key_done) begin
         pend_in[cur_key] = 1'b0;
      end
      last_word = !has_event || (pend_in == '0);

      word_in.event_valid   = has_event;
      word_in.is_note_on    = has_event && cur_on;
      word_in.note_number   = has_event ? layer_notes[cur_key] : '0;
      word_in.note_velocity = (has_event && cur_on) ? cfg.on_velocity : '0;
      word_in.channel_out   = cfg.midi_channel;
      word_in.led_mask      = kme_pkg::LED_W'(cmd_ff.held);
      word_in.last_of_scan  = last_word;

      lay_in = key_done ? '0 : lay_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kme_pkg::BACK_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= '0;
         lay_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (queue_pop) begin
            pend_ff <= queue_cmd.on_mask | queue_cmd.off_mask;
            lay_ff  <= '0;
         end else if (emit) begin
            pend_ff <= pend_in;
            lay_ff  <= lay_in;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         cmd_ff <= queue_cmd;
      end
      if (emit) begin
         rsp_word_ff <= word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_layer_bound: assert property (@(posedge clock) disable iff (reset)
      lay_ff <= LAST_LAYER)
      else $error("note-off layer counter ran past the last layer");

   a_off_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_word_ff.is_note_on) |-> rsp_word_ff.note_velocity == '0)
      else $error("note-off or empty word carries a velocity");

   a_on_is_event: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.is_note_on) |-> rsp_word_ff.event_valid)
      else $error("note-on flagged on a word without an event");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (emit && last_word) |=> state_ff == kme_pkg::BACK_IDLE)
      else $error("sequencer kept running after the last word of a scan");

endmodule

FILE: rtl/keypad_to_midi_note_events.sv
// Top level of the keypad to MIDI note event encoder: register file, front end, queue, sequencer.
//
//   Channel | Ports    | Direction | Contents (lowest bit first)
//   --------+----------+-----------+------------------------------------------------------
//   scan    | req_*    | in        | tdata: key_bits[5:0], two unused bits
//   event   | rsp_*    | out       | tdata: note_number, note_velocity, channel_out,
//           |          |           |        led_mask, one zero bit; tuser: event_valid,
//           |          |           |        is_note_on; tlast: last_of_scan
//   config  | csr_*    | in        | write enable, register index, write data
//
// A scan word is classified and queued in the cycle it is accepted. The sequencer loads a
// queued scan while idle and then emits one result word per cycle while its output register
// is free.
// A scan with no events still yields exactly one word, marked with tlast.
// Reset is synchronous and active high. It clears the held keys, the queue and the
// sequencer, and loads the registers with their reset values (velocity 99, channel 1,
// note tables zero).
// The queue holds two scans, so the scan side keeps accepting words while the event side
// is stalled until the queue is full, and a finished word waits in the output register,
// holding the sequencer until the event side takes it.
module keypad_to_midi_note_events #(
   parameter int NOTE_KEYS = 4,
   parameter int LAYERS    = 4
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [kme_pkg::REQ_DATA_W-1:0]   req_tdata,   // key_bits[5:0]

   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [kme_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // note_number, note_velocity,
                                                         // channel_out, led_mask
   output logic [kme_pkg::RSP_USER_W-1:0]   rsp_tuser,   // event_valid, is_note_on
   output logic                             rsp_tlast,

   input  logic                             csr_we,
   input  logic [kme_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kme_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   kme_pkg::cfg_type           cfg_ff;
   kme_pkg::cfg_type           cfg_in;
   kme_pkg::queue_status_type  queue_status;
   kme_pkg::scan_cmd_type      push_cmd;
   kme_pkg::scan_cmd_type      pop_cmd;
   logic                       queue_push;
   logic                       queue_pop;
   logic                       rsp_valid;
   kme_pkg::result_type        rsp_word;

   // Register file. Writes to an index with no register are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index) inside
            kme_pkg::CSR_LAYER0_NOTES, kme_pkg::CSR_LAYER1_NOTES,
            kme_pkg::CSR_LAYER2_NOTES, kme_pkg::CSR_LAYER3_NOTES: begin
               cfg_in.note_tables[csr_index[kme_pkg::LAYER_W-1:0]] =
                  csr_wdata[kme_pkg::TABLE_W-1:0];
            end
            kme_pkg::CSR_ON_VELOCITY: begin
               cfg_in.on_velocity = csr_wdata[kme_pkg::VEL_W-1:0];
            end
            kme_pkg::CSR_MIDI_CHANNEL: begin
               cfg_in.midi_channel = csr_wdata[kme_pkg::CHAN_W-1:0];
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.note_tables  <= '0;
         cfg_ff.on_velocity  <= kme_pkg::VEL_RESET;
         cfg_ff.midi_channel <= kme_pkg::CHAN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   kme_front #(
      .NOTE_KEYS (NOTE_KEYS),
      .LAYERS    (LAYERS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .key_bits     (req_tdata[kme_pkg::KEY_BITS-1:0]),
      .queue_status (queue_status),
      .queue_push   (queue_push),
      .queue_cmd    (push_cmd)
   );

   kme_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .push_cmd (push_cmd),
      .pop      (queue_pop),
      .pop_cmd  (pop_cmd),
      .status   (queue_status)
   );

   kme_back #(
      .LAYERS (LAYERS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .queue_status (queue_status),
      .queue_cmd    (pop_cmd),
      .queue_pop    (queue_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_tready),
      .rsp_word     (rsp_word)
   );

   // Pack the result word onto the stream; the spare top bit of tdata is zero.
   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata  = {1'b0, rsp_word.led_mask, rsp_word.channel_out,
                        rsp_word.note_velocity, rsp_word.note_number};
   assign rsp_tuser  = {rsp_word.is_note_on, rsp_word.event_valid};
   assign rsp_tlast  = rsp_word.last_of_scan;

endmodule
